// ===== sv/six_axis_wrench_transform_filter_defines.svh =====
// Assertion macros for the six-axis wrench transform filter.
// Taken in by the top level; expects aclk and aresetn in scope.
`ifndef SIX_AXIS_WRENCH_TRANSFORM_FILTER_DEFINES_SVH
`define SIX_AXIS_WRENCH_TRANSFORM_FILTER_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define SWTF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check a next-cycle implication outside reset
`define SWTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swtf_pkg.sv =====
// Shared types, constants and micro-op tables for the wrench transform filter.
// No dependencies; used by swtf_mac and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swtf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int AXES        = 6;
    localparam int FRAC        = 30;
    localparam int COEF_W      = 32;
    localparam int OP_W        = SAMPLE_BITS + 1;
    localparam int PROD_W      = COEF_W + OP_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int AXIS_W      = 3;
    localparam int CFG_IDX_W   = 3;

    // Q2.30 coefficients
    localparam logic signed [COEF_W-1:0] K_ONE = 32'sd1073741824;
    localparam logic signed [COEF_W-1:0] K_035 = 32'sd37580964;
    localparam logic signed [COEF_W-1:0] K_075 = 32'sd80530637;
    localparam logic signed [COEF_W-1:0] K_B0  = 32'sd47393266;
    localparam logic signed [COEF_W-1:0] K_B1  = 32'sd94786531;
    localparam logic signed [COEF_W-1:0] K_A1  = 32'sd1421797966;
    localparam logic signed [COEF_W-1:0] K_A2  = 32'sd537629204;

    // Sequencer step limits
    localparam logic [2:0]        XFORM_LAST = 3'd6;
    localparam logic [2:0]        TAP_LAST   = 3'd4;
    localparam logic [AXIS_W-1:0] FNUM_LAST  = AXIS_W'(AXES - 1);
    localparam logic [AXIS_W-1:0] HALF_AXES  = AXIS_W'(AXES / 2);

    typedef logic [AXIS_W-1:0] axis_t;

    typedef enum logic [3:0] {
        C_ONE, C_K035, C_NEG_K035, C_K075, C_NEG_K075, C_B0, C_B1, C_A1, C_NEG_A2
    } coef_sel_t;

    typedef enum logic [2:0] {
        SRC_D, SRC_H, SRC_X1, SRC_X2, SRC_Y1, SRC_Y2
    } src_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_XFORM, ST_FILTER, ST_DRAIN, ST_DONE
    } state_t;

    // Tag that travels with a product through the shared unit
    typedef struct packed {
        logic  first;
        logic  last;
        logic  filt;
        axis_t dax;
    } mac_tag_t;

    typedef struct packed {
        coef_sel_t coef;
        src_sel_t  src;
        axis_t     sidx;
        mac_tag_t  tag;
    } uop_t;

    function automatic logic signed [COEF_W-1:0] coef_value(input coef_sel_t c);
        logic signed [COEF_W-1:0] v;
        unique case (c)
            C_ONE:      v = K_ONE;
            C_K035:     v = K_035;
            C_NEG_K035: v = -K_035;
            C_K075:     v = K_075;
            C_NEG_K075: v = -K_075;
            C_B0:       v = K_B0;
            C_B1:       v = K_B1;
            C_A1:       v = K_A1;
            C_NEG_A2:   v = -K_A2;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // Transform: d holds raw minus offset, before the z negations.
    //   mx' = mx + 0.035*fy ; my' = mz + 0.075*fy ; mz' = my - 0.035*fx - 0.075*fz
    function automatic uop_t xform_uop(input logic [2:0] step);
        uop_t u;
        u = '{coef: C_ONE, src: SRC_D, sidx: '0,
              tag: '{first: 1'b0, last: 1'b0, filt: 1'b0, dax: '0}};
        unique case (step)
            3'd0: begin u.coef = C_ONE;      u.sidx = 3'd3; u.tag.first = 1'b1;
                        u.tag.dax = 3'd0; end
            3'd1: begin u.coef = C_K035;     u.sidx = 3'd1; u.tag.last = 1'b1;
                        u.tag.dax = 3'd0; end
            3'd2: begin u.coef = C_ONE;      u.sidx = 3'd5; u.tag.first = 1'b1;
                        u.tag.dax = 3'd1; end
            3'd3: begin u.coef = C_K075;     u.sidx = 3'd1; u.tag.last = 1'b1;
                        u.tag.dax = 3'd1; end
            3'd4: begin u.coef = C_ONE;      u.sidx = 3'd4; u.tag.first = 1'b1;
                        u.tag.dax = 3'd2; end
            3'd5: begin u.coef = C_NEG_K035; u.sidx = 3'd0; u.tag.dax = 3'd2; end
            3'd6: begin u.coef = C_NEG_K075; u.sidx = 3'd2; u.tag.last = 1'b1;
                        u.tag.dax = 3'd2; end
            default: u.coef = C_ONE;
        endcase
        return u;
    endfunction

    // Filter taps: b0*x + b1*x1 + b0*x2 + a1*y1 - a2*y2
    function automatic uop_t filter_uop(input logic [2:0] tap, input axis_t ax);
        uop_t u;
        u = '{coef: C_B0, src: SRC_H, sidx: ax,
              tag: '{first: 1'b0, last: 1'b0, filt: 1'b1, dax: ax}};
        unique case (tap)
            3'd0: begin u.coef = C_B0;     u.src = SRC_H;  u.tag.first = 1'b1; end
            3'd1: begin u.coef = C_B1;     u.src = SRC_X1; end
            3'd2: begin u.coef = C_B0;     u.src = SRC_X2; end
            3'd3: begin u.coef = C_A1;     u.src = SRC_Y1; end
            3'd4: begin u.coef = C_NEG_A2; u.src = SRC_Y2; u.tag.last = 1'b1; end
            default: u.coef = C_B0;
        endcase
        return u;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_acc(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/swtf_mac.sv =====
// Shared multiply-accumulate unit: registered product, accumulator, round and saturate.
// Depends on swtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swtf_mac (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     issue_valid,
    input  wire logic signed [swtf_pkg::COEF_W-1:0]       coef,
    input  wire logic signed [swtf_pkg::OP_W-1:0]         operand,
    input  wire swtf_pkg::mac_tag_t                       tag_in,
    output logic                                          res_valid,
    output swtf_pkg::mac_tag_t                            res_tag,
    output logic signed [swtf_pkg::SAMPLE_BITS-1:0]       res_value
);

    logic                                   v1_reg;
    swtf_pkg::mac_tag_t                     tag1_reg;
    logic signed [swtf_pkg::PROD_W-1:0]     prod_reg;
    logic signed [swtf_pkg::ACC_W-1:0]      acc_reg;
    logic signed [swtf_pkg::ACC_W-1:0]      acc_next;
    logic                                   v2_reg;
    swtf_pkg::mac_tag_t                     tag2_reg;
    logic signed [swtf_pkg::ACC_W-1:0]      rnd;
    logic signed [swtf_pkg::ACC_W-1:0]      quo;

    // Stage one: register the product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= issue_valid;
        end
        tag1_reg <= tag_in;
        prod_reg <= coef * operand;
    end

    // Stage two: accumulate, restarting on the first product of a sum
    always_comb begin
        if (tag1_reg.first) begin
            acc_next = swtf_pkg::ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + swtf_pkg::ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg && tag1_reg.last;
        end
        if (v1_reg) begin
            acc_reg <= acc_next;
        end
        tag2_reg <= tag1_reg;
    end

    // Round half up at the binary point, then saturate to a sample
    always_comb begin
        rnd = acc_reg + (swtf_pkg::ACC_W'(1) <<< (swtf_pkg::FRAC - 1));
        quo = rnd >>> swtf_pkg::FRAC;
    end

    assign res_valid = v2_reg;
    assign res_tag   = tag2_reg;
    assign res_value = swtf_pkg::sat_acc(quo);

endmodule

`default_nettype wire

// ===== sv/six_axis_wrench_transform_filter.sv =====
// Six-axis wrench transform into the handle frame, then a second-order low-pass per axis.
// One item is in work at a time: a new word is taken only in idle, after the transform, the filter
// taps (skipped while priming), drain and done of the last one. All products share the single multiply-accumulate.
// The result word is registered in done once the output register is free or being taken.
// aresetn is synchronous, active low: clears offsets, filter history and priming count.
// Depends on swtf_pkg, swtf_mac and six_axis_wrench_transform_filter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "six_axis_wrench_transform_filter_defines.svh"

module six_axis_wrench_transform_filter (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    // tdata: raw_fx, raw_fy, raw_fz, raw_mx, raw_my, raw_mz
    input  wire logic [swtf_pkg::AXES*swtf_pkg::SAMPLE_BITS-1:0] s_tdata,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // tdata: out_mx, out_my, out_mz, out_fx, out_fy, out_fz
    output logic [swtf_pkg::AXES*swtf_pkg::SAMPLE_BITS-1:0]   m_tdata,
    // tuser: primed
    output logic                                              m_tuser,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    input  wire logic                                         cfg_valid,
    output logic                                              cfg_ready,
    input  wire logic [swtf_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  wire logic [swtf_pkg::SAMPLE_BITS-1:0]             cfg_data
);

    localparam int SB = swtf_pkg::SAMPLE_BITS;

    swtf_pkg::state_t                   state_reg, state_next;
    logic [2:0]                         step_reg;
    swtf_pkg::axis_t                    fnum_reg;
    swtf_pkg::axis_t                    fax;
    logic                               drain_reg;
    logic                               filt_reg;
    logic [1:0]                         warmup_reg;

    logic signed [SB-1:0]               offset_reg [swtf_pkg::AXES];
    logic signed [swtf_pkg::OP_W-1:0]   d_reg      [swtf_pkg::AXES];
    logic signed [SB-1:0]               h_reg      [swtf_pkg::AXES];
    logic signed [SB-1:0]               x1_reg     [swtf_pkg::AXES];
    logic signed [SB-1:0]               x2_reg     [swtf_pkg::AXES];
    logic signed [SB-1:0]               y1_reg     [swtf_pkg::AXES];
    logic signed [SB-1:0]               y2_reg     [swtf_pkg::AXES];

    logic [swtf_pkg::AXES*SB-1:0]       m_tdata_reg;
    logic                               m_tuser_reg;
    logic                               m_tvalid_reg;

    logic                               accept;
    logic                               issue_valid;
    logic                               done_go;
    swtf_pkg::uop_t                     uop;
    logic signed [swtf_pkg::OP_W-1:0]   operand;
    logic                               res_valid;
    swtf_pkg::mac_tag_t                 res_tag;
    logic signed [SB-1:0]               res_value;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Filter order: force axes first, their inputs are ready at acceptance
    assign fax = (fnum_reg < swtf_pkg::HALF_AXES) ? fnum_reg + swtf_pkg::HALF_AXES
                                                  : fnum_reg - swtf_pkg::HALF_AXES;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swtf_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = swtf_pkg::ST_XFORM;
            end
            swtf_pkg::ST_XFORM: begin
                if (step_reg == swtf_pkg::XFORM_LAST) begin
                    state_next = filt_reg ? swtf_pkg::ST_FILTER : swtf_pkg::ST_DRAIN;
                end
            end
            swtf_pkg::ST_FILTER: begin
                if (step_reg == swtf_pkg::TAP_LAST && fnum_reg == swtf_pkg::FNUM_LAST) begin
                    state_next = swtf_pkg::ST_DRAIN;
                end
            end
            swtf_pkg::ST_DRAIN: begin
                if (drain_reg) state_next = swtf_pkg::ST_DONE;
            end
            swtf_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = swtf_pkg::ST_IDLE;
            end
            default: state_next = swtf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready    = 1'b0;
        issue_valid = 1'b0;
        done_go     = 1'b0;
        unique case (state_reg)
            swtf_pkg::ST_IDLE:   s_tready    = 1'b1;
            swtf_pkg::ST_XFORM:  issue_valid = 1'b1;
            swtf_pkg::ST_FILTER: issue_valid = 1'b1;
            swtf_pkg::ST_DRAIN:  issue_valid = 1'b0;
            swtf_pkg::ST_DONE:   done_go     = !m_tvalid_reg || m_tready;
            default:             s_tready    = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swtf_pkg::ST_IDLE;
            step_reg  <= '0;
            fnum_reg  <= '0;
            drain_reg <= 1'b0;
            filt_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                step_reg  <= '0;
                fnum_reg  <= '0;
                drain_reg <= 1'b0;
                filt_reg  <= (warmup_reg == 2'd2);
            end else if (state_reg == swtf_pkg::ST_XFORM) begin
                step_reg <= (step_reg == swtf_pkg::XFORM_LAST) ? 3'd0 : step_reg + 3'd1;
            end else if (state_reg == swtf_pkg::ST_FILTER) begin
                if (step_reg == swtf_pkg::TAP_LAST) begin
                    step_reg <= '0;
                    fnum_reg <= fnum_reg + swtf_pkg::AXIS_W'(1);
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end else if (state_reg == swtf_pkg::ST_DRAIN) begin
                drain_reg <= 1'b1;
            end
        end
    end

    // Select the micro-op and its operand
    always_comb begin
        if (state_reg == swtf_pkg::ST_FILTER) begin
            uop = swtf_pkg::filter_uop(step_reg, fax);
        end else begin
            uop = swtf_pkg::xform_uop(step_reg);
        end
        unique case (uop.src)
            swtf_pkg::SRC_D:  operand = d_reg[uop.sidx];
            swtf_pkg::SRC_H:  operand = swtf_pkg::OP_W'(h_reg[uop.sidx]);
            swtf_pkg::SRC_X1: operand = swtf_pkg::OP_W'(x1_reg[uop.sidx]);
            swtf_pkg::SRC_X2: operand = swtf_pkg::OP_W'(x2_reg[uop.sidx]);
            swtf_pkg::SRC_Y1: operand = swtf_pkg::OP_W'(y1_reg[uop.sidx]);
            swtf_pkg::SRC_Y2: operand = swtf_pkg::OP_W'(y2_reg[uop.sidx]);
            default:          operand = '0;
        endcase
    end

    swtf_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue_valid (issue_valid),
        .coef        (swtf_pkg::coef_value(uop.coef)),
        .operand     (operand),
        .tag_in      (uop.tag),
        .res_valid   (res_valid),
        .res_tag     (res_tag),
        .res_value   (res_value)
    );

    // Offsets from the configuration port; indexes past the last axis are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < swtf_pkg::AXES; i++) offset_reg[i] <= '0;
        end else if (cfg_valid && cfg_ready &&
                     cfg_index < swtf_pkg::CFG_IDX_W'(swtf_pkg::AXES)) begin
            offset_reg[cfg_index] <= $signed(cfg_data);
        end
    end

    // Offset-corrected sample, held for the transform
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < swtf_pkg::AXES; i++) begin
                d_reg[i] <= swtf_pkg::OP_W'($signed(s_tdata[i*SB +: SB]))
                          - swtf_pkg::OP_W'(offset_reg[i]);
            end
        end
    end

    // Handle-frame inputs and filter history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < swtf_pkg::AXES; i++) begin
                h_reg[i]  <= '0;
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
            warmup_reg <= '0;
        end else begin
            if (accept) begin
                // forces are a plain rotation: fx' = fx, fy' = -fz (= raw fz), fz' = fy
                h_reg[3] <= swtf_pkg::sat_acc(swtf_pkg::ACC_W'(
                    swtf_pkg::OP_W'($signed(s_tdata[0*SB +: SB])) - swtf_pkg::OP_W'(offset_reg[0])));
                h_reg[4] <= swtf_pkg::sat_acc(swtf_pkg::ACC_W'(
                    swtf_pkg::OP_W'($signed(s_tdata[2*SB +: SB])) - swtf_pkg::OP_W'(offset_reg[2])));
                h_reg[5] <= swtf_pkg::sat_acc(swtf_pkg::ACC_W'(
                    swtf_pkg::OP_W'($signed(s_tdata[1*SB +: SB])) - swtf_pkg::OP_W'(offset_reg[1])));
            end
            if (res_valid && !res_tag.filt) begin
                h_reg[res_tag.dax] <= res_value;
            end
            if (res_valid && res_tag.filt) begin
                x2_reg[res_tag.dax] <= x1_reg[res_tag.dax];
                x1_reg[res_tag.dax] <= h_reg[res_tag.dax];
                y2_reg[res_tag.dax] <= y1_reg[res_tag.dax];
                y1_reg[res_tag.dax] <= res_value;
            end
            // priming: fill the input history only
            if (done_go && !filt_reg) begin
                for (int i = 0; i < swtf_pkg::AXES; i++) begin
                    if (warmup_reg == 2'd0) begin
                        x2_reg[i] <= h_reg[i];
                    end else begin
                        x1_reg[i] <= h_reg[i];
                    end
                end
                warmup_reg <= warmup_reg + 2'd1;
            end
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (done_go) begin
            for (int i = 0; i < swtf_pkg::AXES; i++) begin
                m_tdata_reg[i*SB +: SB] <= filt_reg ? y1_reg[i] : '0;
            end
            m_tuser_reg <= filt_reg;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    `SWTF_ASSERT(a_prime_zero, !(m_tvalid && !m_tuser) || m_tdata == '0,
        "priming word carries non-zero data")
    `SWTF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input taken again while an item is in work")
    `SWTF_ASSERT(a_warmup_range, warmup_reg != 2'd3, "priming count past full")
    `SWTF_ASSERT_NEXT(a_result_in_drain, res_valid && res_tag.last && !res_tag.filt,
        state_reg != swtf_pkg::ST_IDLE, "transform result outside an item")

endmodule

`default_nettype wire

// ===== sim/six_axis_wrench_transform_filter_tb.sv =====
// Self-checking testbench for the six-axis wrench transform filter.
// Drives raw wrench words with random gaps, predicts every result and compares.
// Depends on swtf_pkg and six_axis_wrench_transform_filter.
`timescale 1ns / 1ps

module six_axis_wrench_transform_filter_tb;

    localparam int SB = swtf_pkg::SAMPLE_BITS;
    localparam int AXES = swtf_pkg::AXES;
    localparam int N_RANDOM = 750;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam longint Q_ONE = 64'sd1073741824;
    localparam longint Q_035 = 64'sd37580964;
    localparam longint Q_075 = 64'sd80530637;
    localparam longint Q_B0  = 64'sd47393266;
    localparam longint Q_B1  = 64'sd94786531;
    localparam longint Q_A1  = 64'sd1421797966;
    localparam longint Q_A2  = 64'sd537629204;

    typedef struct packed {
        logic        primed;
        logic [95:0] wrench;
    } wrench_out_t;

    logic aclk;
    logic aresetn;
    logic [AXES*SB-1:0] s_tdata;
    logic s_tvalid;
    logic s_tready;
    logic [AXES*SB-1:0] m_tdata;
    logic m_tuser;
    logic m_tvalid;
    logic m_tready;
    logic cfg_valid;
    logic cfg_ready;
    logic [swtf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [SB-1:0] cfg_data;

    six_axis_wrench_transform_filter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state
    longint offsets[AXES];
    longint x1_hist[AXES];
    longint x2_hist[AXES];
    longint y1_hist[AXES];
    longint y2_hist[AXES];
    int     warm_count;

    wrench_out_t expected_wrenches[$];
    int  error_count;
    bit  sink_hold;
    bit  stim_done;
    int  idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp_sample(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Round half up at the binary point, floor semantics
    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic wrench_out_t predict_wrench(input logic [95:0] raw);
        longint s[AXES];
        longint h[AXES];
        longint acc;
        wrench_out_t r;
        r = '0;
        for (int i = 0; i < AXES; i++)
            s[i] = longint'($signed(raw[i*SB +: SB])) - offsets[i];
        s[2] = -s[2];
        s[5] = -s[5];
        h[0] = clamp_sample(round_q30(s[3] * Q_ONE + Q_035 * s[1]));
        h[1] = clamp_sample(round_q30(-s[5] * Q_ONE + Q_075 * s[1]));
        h[2] = clamp_sample(round_q30(s[4] * Q_ONE - Q_035 * s[0] + Q_075 * s[2]));
        h[3] = clamp_sample(s[0]);
        h[4] = clamp_sample(-s[2]);
        h[5] = clamp_sample(s[1]);
        if (warm_count == 0) begin
            for (int i = 0; i < AXES; i++) x2_hist[i] = h[i];
            warm_count = 1;
        end else if (warm_count == 1) begin
            for (int i = 0; i < AXES; i++) x1_hist[i] = h[i];
            warm_count = 2;
        end else begin
            for (int i = 0; i < AXES; i++) begin
                acc = Q_B0 * h[i] + Q_B1 * x1_hist[i] + Q_B0 * x2_hist[i]
                    + Q_A1 * y1_hist[i] - Q_A2 * y2_hist[i];
                acc = clamp_sample(round_q30(acc));
                y2_hist[i] = y1_hist[i];
                y1_hist[i] = acc;
                x2_hist[i] = x1_hist[i];
                x1_hist[i] = h[i];
                r.wrench[i*SB +: SB] = acc[SB-1:0];
            end
            r.primed = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Write one offset register; the block must be idle
    task automatic write_offset(input logic [2:0] idx, input logic [SB-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx < AXES) offsets[idx] = longint'($signed(val));
        @(posedge aclk);
    endtask

    // Offer one word; valid stays up after acceptance so a following word can go straight on
    task automatic send_wrench(input logic [95:0] raw, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= raw;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_wrenches.push_back(predict_wrench(raw));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_wrenches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [95:0] pack_six(input logic [SB-1:0] a, b, c, d, e, f);
        return {f, e, d, c, b, a};
    endfunction

    function automatic logic [95:0] random_wrench();
        logic [95:0] w;
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < AXES; i++) begin
            if (mode == 0) w[i*SB +: SB] = SB'($urandom());
            else if (mode == 1) w[i*SB +: SB] = SB'($signed($urandom_range(0, 400)) - 200);
            else if (mode == 2) w[i*SB +: SB] = ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
            else w[i*SB +: SB] = SB'($signed($urandom_range(0, 8000)) - 4000);
        end
        return w;
    endfunction

    // Result sink: random stalls plus one long hold-off
    initial begin
        int wait_n;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            m_tready <= 1'b0;
            if (sink_hold) begin
                repeat (400) @(posedge aclk);
                sink_hold = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            repeat (wait_n) @(posedge aclk);
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        wrench_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_wrenches.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = expected_wrenches.pop_front();
                if (m_tuser !== want.primed)
                    report_mismatch("primed", m_tuser, want.primed);
                for (int i = 0; i < AXES; i++)
                    if (m_tdata[i*SB +: SB] !== want.wrench[i*SB +: SB])
                        report_mismatch($sformatf("axis %0d", i),
                            $signed(m_tdata[i*SB +: SB]), $signed(want.wrench[i*SB +: SB]));
            end
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !stim_done) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    typedef struct {
        logic [95:0] raw;
        bit          known;
        logic [95:0] want;
    } stim_row_t;

    initial begin
        stim_row_t rows[$];
        logic [SB-1:0] ofs;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        sink_hold = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        warm_count = 0;
        for (int i = 0; i < AXES; i++) begin
            offsets[i] = 0; x1_hist[i] = 0; x2_hist[i] = 0; y1_hist[i] = 0; y2_hist[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: priming samples, extremes, zero and steady inputs
        rows.push_back('{pack_six(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000),
                         1'b1, '0});
        rows.push_back('{pack_six(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff),
                         1'b1, '0});
        rows.push_back('{'0, 1'b0, '0});
        rows.push_back('{{6{16'h7fff}}, 1'b0, '0});
        rows.push_back('{{6{16'h8000}}, 1'b0, '0});
        rows.push_back('{{6{16'hffff}}, 1'b0, '0});
        rows.push_back('{{6{16'h0001}}, 1'b0, '0});
        for (int i = 0; i < 8; i++) rows.push_back('{{6{16'd1000}}, 1'b0, '0});
        for (int i = 0; i < 4; i++) rows.push_back('{{6{16'h5555}}, 1'b0, '0});
        foreach (rows[k]) begin
            send_wrench(rows[k].raw, 1'b0);
            if (rows[k].known && expected_wrenches[$] !== {1'b0, rows[k].want})
                report_mismatch("priming prediction", k, 0);
        end
        drain_results();

        // Offsets at extremes, a random setting and zero, each followed by random words
        for (int phase = 0; phase < 4; phase++) begin
            for (int r = 0; r < AXES; r++) begin
                case (phase)
                    0: ofs = 16'h7fff;
                    1: ofs = 16'h8000;
                    2: ofs = SB'($urandom());
                    default: ofs = '0;
                endcase
                write_offset(r[2:0], ofs);
            end
            write_offset(REG_UNUSED, SB'($urandom()));
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if (phase == 1 && n == 20) sink_hold = 1'b1;
                if (phase == 2 && n == 50) begin
                    s_tvalid <= 1'b0;
                    while (expected_wrenches.size() != 0) @(posedge aclk);
                end
                send_wrench(random_wrench(), ($urandom_range(0, 4) != 0));
            end
            drain_results();
        end

        stim_done = 1'b1;
        if (error_count == 0 && expected_wrenches.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
